FILE: hdl/fpeb_pkg.sv
// Package: shared constants, types and state encoding for the frustum cull unit.
package fpeb_pkg;
	localparam int FRAC_BITS_DEF = 16;
	localparam int NUM_PLANES = 6;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_BOX  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_LOAD,
		ST_EX_RD,
		ST_EX_CMP,
		ST_EX_SQ,
		ST_EX_SQRT,
		ST_EX_DIV,
		ST_EX_WR,
		ST_BOX_RD,
		ST_BOX_MAC,
		ST_BOX_CHK,
		ST_BOX_OUT
	} fpeb_state_t;

	typedef struct packed {
		logic start;
		logic signed [31:0] num;
		logic [32:0] den;
	} div_req_t;

	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		if (v > 34'sh0_7FFF_FFFF) return 32'h7FFF_FFFF;
		if (v < -34'sh0_8000_0000) return 32'h8000_0000;
		return v[31:0];
	endfunction
endpackage

FILE: hdl/fpeb_isqrt.sv
// Iterative integer square root, one result bit per cycle.
module fpeb_isqrt import fpeb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [65:0] radicand,
	output logic        done,
	output logic [32:0] root
);
	logic [65:0] rem_q;
	logic [32:0] root_q;
	logic [67:0] acc_q;
	logic [5:0]  cnt_q;
	logic        run_q;
	logic [67:0] acc_n;
	logic [67:0] trial;

	always_comb begin
		acc_n = {acc_q[65:0], rem_q[65:64]};
		trial = {root_q, 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= 6'd33;
				done  <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q - 6'd1;
				run_q <= (cnt_q != 6'd1);
				done  <= (cnt_q == 6'd1);
			end else begin
				done <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= radicand;
			root_q <= '0;
			acc_q  <= '0;
		end else if (run_q) begin
			rem_q <= {rem_q[63:0], 2'b00};
			if (acc_n >= trial) begin
				acc_q  <= acc_n - trial;
				root_q <= {root_q[31:0], 1'b1};
			end else begin
				acc_q  <= acc_n;
				root_q <= {root_q[31:0], 1'b0};
			end
		end
	end

	assign root = root_q;
endmodule

FILE: hdl/fpeb_div.sv
// Iterative restoring divider for (a << F) / len with saturation.
module fpeb_div import fpeb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  div_req_t           req,
	output logic               done,
	output logic signed [31:0] quot
);
	localparam int NW = 32 + FRAC_BITS;
	logic [NW-1:0] num_q;
	logic [NW-1:0] q_q;
	logic [32:0]   den_q;
	logic [33:0]   rem_q;
	logic          neg_q;
	logic [6:0]    cnt_q;
	logic          run_q;
	logic [33:0]   rem_sh;
	logic [NW:0]   qmax;

	assign rem_sh = {rem_q[32:0], num_q[NW-1]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done  <= 1'b0;
		end else begin
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= 7'(NW);
				done  <= 1'b0;
			end else if (run_q) begin
				cnt_q <= cnt_q - 7'd1;
				run_q <= (cnt_q != 7'd1);
				done  <= (cnt_q == 7'd1);
			end else begin
				done <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			neg_q <= req.num[31];
			num_q <= NW'(req.num[31] ? 33'(-$signed({req.num[31], req.num}))
				: 33'({1'b0, req.num})) << FRAC_BITS;
			den_q <= req.den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			if (rem_sh >= {1'b0, den_q}) begin
				rem_q <= rem_sh - {1'b0, den_q};
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= rem_sh;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end

	always_comb begin
		qmax = {1'b0, q_q};
		if (!neg_q) quot = (qmax > (NW+1)'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : q_q[31:0];
		else if (qmax >= (NW+1)'(33'h1_0000_0000 >> 1)) quot = 32'h8000_0000;
		else quot = -$signed(q_q[31:0]);
	end
endmodule

FILE: hdl/frustum_plane_extract_box_cull_unit.sv
// Top level: frustum plane extraction and box cull around two state memories.
//
// channel  direction  handshake          word
// input    in         start & !busy      func, matrix_index, matrix_value, last_element, box
// result   out        done (one cycle)   inside_res, degenerate_plane
//
// A plain load passes through the LOAD state before the next accept. A box walks the
// planes one by one (offset read, three multiplies, check); a box that passes all six
// raises done from BOX_OUT after the last check, and a reject ends the walk at the
// failing plane. A load marked last keeps the unit busy while it extracts all six
// planes, each by reads, squares, the serial square root, the divider and a write;
// a zero-length plane skips division. Reset clears the valid bits of both memories;
// the receiver cannot stall, so done pulses for exactly one cycle.
module frustum_plane_extract_box_cull_unit import fpeb_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [3:0]         matrix_index,
	input  logic signed [31:0] matrix_value,
	input  logic               last_element,
	input  logic signed [31:0] box_min_x,
	input  logic signed [31:0] box_min_y,
	input  logic signed [31:0] box_min_z,
	input  logic signed [31:0] box_max_x,
	input  logic signed [31:0] box_max_y,
	input  logic signed [31:0] box_max_z,
	output logic               done,
	output logic               inside_res,
	output logic               degenerate_plane
);
	// matrix memory: 16 words, one read port
	logic signed [31:0] mat_mem [16];
	logic [15:0]        mat_vld_q;
	logic [3:0]         mat_ra;
	logic signed [31:0] mat_rd_s1;
	logic               mat_rv_s1;

	// plane memory: 24 words, plane*4 + comp (comp 3 = offset)
	logic signed [31:0] pl_mem [24];
	logic [23:0]        pl_vld_q;
	logic [4:0]         pl_ra;
	logic signed [31:0] pl_rd_s1;
	logic               pl_rv_s1;
	logic               pl_we;
	logic [4:0]         pl_wa;
	logic signed [31:0] pl_wd;

	fpeb_state_t        st_q, st_n;
	logic [2:0]         plane_q;
	logic [2:0]         step_q;
	logic               degen_q;
	logic               inside_q;
	logic               last_flag_q;
	logic               ph_q;
	logic [3:0]         mat_ra_eff;
	logic signed [31:0] a_q;
	logic signed [31:0] comp_q [4];
	logic [65:0]        sq_q;
	logic [32:0]        len_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] acc_q;
	logic signed [65:0] acc_fin;
	logic signed [31:0] bmin_q [3];
	logic signed [31:0] bmax_q [3];

	logic               sq_start, sq_done;
	logic [32:0]        sq_root;
	div_req_t           dreq;
	logic               d_done;
	logic signed [31:0] d_quot;

	logic signed [31:0] mat_val, pl_val;
	assign mat_val = mat_rv_s1 ? mat_rd_s1 : '0;
	assign pl_val  = pl_rv_s1 ? pl_rd_s1 : '0;

	logic accept;
	assign accept = start && !busy;

	// distance of the plane with the last product folded in
	assign acc_fin = acc_q + 66'(prod_q);

	fpeb_isqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .radicand(sq_q),
		.done(sq_done), .root(sq_root)
	);

	fpeb_div #(.FRAC_BITS(FRAC_BITS)) u_div (
		.clk(clk), .arst_n(arst_n), .req(dreq), .done(d_done), .quot(d_quot)
	);

	// next state
	always_comb begin
		st_n = st_q;
		unique case (st_q)
			ST_IDLE:    if (accept) st_n = (func == FUNC_BOX) ? ST_BOX_RD : ST_LOAD;
			ST_LOAD:    st_n = last_flag_q ? ST_EX_RD : ST_IDLE;
			ST_EX_RD:   if (step_q == 3'd4) st_n = ST_EX_CMP;
			ST_EX_CMP:  if (step_q == 3'd3) st_n = ST_EX_SQ;
			ST_EX_SQ:   if (step_q == 3'd3) st_n = ST_EX_SQRT;
			ST_EX_SQRT: if (sq_done) st_n = (sq_root == '0) ? ST_EX_WR : ST_EX_DIV;
			ST_EX_DIV:  if (d_done && step_q == 3'd3) st_n = ST_EX_WR;
			ST_EX_WR:   if (step_q == 3'd3)
					st_n = (plane_q == 3'(NUM_PLANES - 1)) ? ST_IDLE : ST_EX_RD;
			ST_BOX_RD:  st_n = ST_BOX_MAC;
			ST_BOX_MAC: if (step_q == 3'd3) st_n = ST_BOX_CHK;
			ST_BOX_CHK: st_n = (acc_fin < 0 || plane_q == 3'(NUM_PLANES - 1))
					? ST_BOX_OUT : ST_BOX_RD;
			ST_BOX_OUT: st_n = ST_IDLE;
			default:    st_n = ST_IDLE;
		endcase
	end

	// outputs and memory addressing
	always_comb begin
		busy     = (st_q != ST_IDLE);
		done     = (st_q == ST_BOX_OUT);
		inside_res = inside_q;
		degenerate_plane = degen_q;
		sq_start = (st_q == ST_EX_SQ) && (step_q == 3'd3);
		dreq.start = 1'b0;
		dreq.num = comp_q[step_q[1:0]];
		dreq.den = len_q;
		// start each division when entering DIV or after a finished one
		if (st_q == ST_EX_SQRT && sq_done && sq_root != '0) begin
			dreq.start = 1'b1;
			dreq.num = comp_q[0];
			dreq.den = sq_root;
		end else if (st_q == ST_EX_DIV && d_done && step_q != 3'd3) begin
			dreq.start = 1'b1;
			dreq.num = comp_q[2'(step_q + 3'd1)];
		end
		// matrix reads: step 0..3 component c, reads col c row 3 then row r
		mat_ra = {step_q[1:0], 2'd3};
		// box walk: offset first (BOX_RD), then normal x, y, z
		pl_ra  = {plane_q[2:0], 2'd3};
		if (st_q == ST_BOX_MAC) pl_ra = {plane_q, step_q[1:0]};
		pl_we = (st_q == ST_EX_WR);
		pl_wa = {plane_q, step_q[1:0]};
		pl_wd = comp_q[step_q[1:0]];
	end

	// extraction reads alternate row 3 and row r; use a two-phase sub step
	assign mat_ra_eff = ph_q ? {step_q[1:0], plane_q[2:1]} : mat_ra;

	// matrix memory with valid bits
	always_ff @(posedge clk) begin
		if (accept && func == FUNC_LOAD) mat_mem[matrix_index] <= matrix_value;
		mat_rd_s1 <= mat_mem[mat_ra_eff];
		pl_rd_s1  <= pl_mem[pl_ra];
		if (pl_we) pl_mem[pl_wa] <= pl_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			mat_vld_q   <= '0;
			pl_vld_q    <= '0;
			mat_rv_s1   <= 1'b0;
			pl_rv_s1    <= 1'b0;
			degen_q     <= 1'b0;
			plane_q     <= '0;
			step_q      <= '0;
			ph_q        <= 1'b0;
			last_flag_q <= 1'b0;
			inside_q    <= 1'b1;
		end else begin
			st_q      <= st_n;
			mat_rv_s1 <= mat_vld_q[mat_ra_eff];
			pl_rv_s1  <= pl_vld_q[pl_ra];
			if (pl_we) pl_vld_q[pl_wa] <= 1'b1;
			unique case (st_q)
				ST_IDLE: begin
					step_q <= '0;
					plane_q <= '0;
					ph_q <= 1'b0;
					if (accept) begin
						last_flag_q <= last_element;
						if (func == FUNC_LOAD) mat_vld_q[matrix_index] <= 1'b1;
						else inside_q <= 1'b1;
					end
				end
				ST_LOAD: if (last_flag_q) degen_q <= 1'b0;
				ST_EX_RD: begin
					// two reads per component: phase 0 col row 3, phase 1 row r
					if (step_q == 3'd4) begin
						step_q <= '0;
						ph_q <= 1'b0;
					end else begin
						ph_q <= !ph_q;
						if (ph_q) step_q <= step_q + 3'd1;
					end
				end
				ST_EX_CMP, ST_EX_SQ, ST_BOX_MAC: begin
					step_q <= (step_q == 3'd3) ? 3'd0 : step_q + 3'd1;
				end
				ST_EX_SQRT: if (sq_done && sq_root == '0) degen_q <= 1'b1;
				ST_EX_DIV: if (d_done) begin
					step_q <= (step_q == 3'd3) ? 3'd0 : step_q + 3'd1;
				end
				ST_EX_WR: begin
					step_q <= (step_q == 3'd3) ? 3'd0 : step_q + 3'd1;
					if (step_q == 3'd3) plane_q <= plane_q + 3'd1;
				end
				ST_BOX_CHK: begin
					plane_q <= plane_q + 3'd1;
					if (acc_fin < 0) inside_q <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	// datapath registers: operand capture, squares, multiply-accumulate
	logic signed [31:0] corner;
	logic [1:0]         axis_sel;
	always_comb begin
		// in the box walk step s carries the normal component of axis s - 1
		axis_sel = (step_q[1:0] == 2'd0) ? 2'd0 : step_q[1:0] - 2'd1;
		corner = (pl_val >= 0) ? bmax_q[axis_sel] : bmin_q[axis_sel];
	end

	always_ff @(posedge clk) begin
		if (accept && func == FUNC_BOX) begin
			bmin_q[0] <= box_min_x; bmin_q[1] <= box_min_y; bmin_q[2] <= box_min_z;
			bmax_q[0] <= box_max_x; bmax_q[1] <= box_max_y; bmax_q[2] <= box_max_z;
		end
		unique case (st_q)
			ST_EX_RD: begin
				// data for the read issued last cycle arrives now
				if (step_q != 3'd0 || ph_q) begin
					if (ph_q) a_q <= mat_val;
					else comp_q[2'(step_q - 3'd1)] <= sat32(plane_q[0]
						? 34'(a_q) - 34'(mat_val) : 34'(a_q) + 34'(mat_val));
				end
			end
			ST_EX_CMP: begin
				prod_q <= 64'(comp_q[step_q[1:0]]) * 64'(comp_q[step_q[1:0]]);
				if (step_q == 3'd0) sq_q <= '0;
				else sq_q <= sq_q + 66'($unsigned(prod_q));
			end
			ST_EX_SQRT: if (sq_done) len_q <= sq_root;
			ST_EX_DIV: if (d_done) comp_q[step_q[1:0]] <= d_quot;
			ST_BOX_RD: ;
			ST_BOX_MAC: begin
				// step 0 loads the offset, steps 2 and 3 fold in the previous product
				if (step_q == 3'd0) acc_q <= 66'(pl_val) <<< FRAC_BITS;
				else if (step_q != 3'd1) acc_q <= acc_q + 66'(prod_q);
				prod_q <= 64'(pl_val) * 64'(corner);
			end
			ST_BOX_CHK: ;
			default: ;
		endcase
	end

	property p_done_pulse;
		@(posedge clk) disable iff (!arst_n) done |=> !done;
	endproperty
	a_done_pulse: assert property (p_done_pulse) else $error("done held");

	property p_busy_after_accept;
		@(posedge clk) disable iff (!arst_n) accept |=> busy;
	endproperty
	a_busy_after_accept: assert property (p_busy_after_accept) else $error("busy");

	property p_plane_range;
		@(posedge clk) disable iff (!arst_n) busy |-> plane_q <= 3'(NUM_PLANES);
	endproperty
	a_plane_range: assert property (p_plane_range) else $error("plane");
endmodule

FILE: test/frustum_cull_checker.sv
// Checker: watches the command and result channels, predicts cull verdicts, compares.
module frustum_cull_checker import fpeb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  logic               func,
	input  logic [3:0]         matrix_index,
	input  logic signed [31:0] matrix_value,
	input  logic               last_element,
	input  logic signed [31:0] box_min_x,
	input  logic signed [31:0] box_min_y,
	input  logic signed [31:0] box_min_z,
	input  logic signed [31:0] box_max_x,
	input  logic signed [31:0] box_max_y,
	input  logic signed [31:0] box_max_z,
	input  logic               done,
	input  logic               inside_res,
	input  logic               degenerate_plane,
	output int                 fail_count,
	output int                 pending_verdicts
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FB = FRAC_BITS_DEF;

	typedef struct packed {
		logic vis;
		logic degen;
	} verdict_t;

	logic signed [31:0] mat [16];
	logic signed [31:0] nrm [18];
	logic signed [31:0] ofs [6];
	logic               degen_flag;
	verdict_t           verdict_q [$];

	function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) return 32'sh7FFF_FFFF;
		if (v < -64'sh8000_0000) return 32'sh8000_0000;
		return v[31:0];
	endfunction

	function automatic logic [63:0] root64(input logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b = b >> 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic logic signed [31:0] scale_by_len(input logic signed [31:0] a,
			input logic [63:0] len);
		logic [63:0] mag, q;
		mag = a[31] ? 64'(-64'(a)) : 64'(a);
		q = (mag << FB) / len;
		if (!a[31]) return (q > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : q[31:0];
		if (q >= 64'h8000_0000) return 32'sh8000_0000;
		return -q[31:0];
	endfunction

	task automatic extract_planes();
		logic signed [31:0] comp [4];
		logic signed [63:0] a, b;
		logic [63:0] sq, len;
		degen_flag = 1'b0;
		for (int p = 0; p < 6; p++) begin
			for (int c = 0; c < 4; c++) begin
				a = mat[c * 4 + 3];
				b = mat[c * 4 + p / 2];
				comp[c] = clamp32(p[0] ? a - b : a + b);
			end
			sq = 0;
			for (int c = 0; c < 3; c++) sq = sq + 64'(64'(comp[c]) * 64'(comp[c]));
			len = root64(sq);
			if (len == 0) degen_flag = 1'b1;
			else for (int c = 0; c < 4; c++) comp[c] = scale_by_len(comp[c], len);
			for (int c = 0; c < 3; c++) nrm[p * 3 + c] = comp[c];
			ofs[p] = comp[3];
		end
	endtask

	function automatic logic box_visible(input logic signed [31:0] lo [3],
			input logic signed [31:0] hi [3]);
		logic signed [63:0] acc;
		for (int p = 0; p < 6; p++) begin
			acc = 64'(ofs[p]) <<< FB;
			for (int c = 0; c < 3; c++)
				acc += 64'(nrm[p * 3 + c]) * 64'(nrm[p * 3 + c] >= 0 ? hi[c] : lo[c]);
			if (acc < 0) return 1'b0;
		end
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		logic signed [31:0] lo [3];
		logic signed [31:0] hi [3];
		verdict_t want;
		if (!arst_n) begin
			for (int i = 0; i < 16; i++) mat[i] = 0;
			for (int i = 0; i < 18; i++) nrm[i] = 0;
			for (int i = 0; i < 6; i++) ofs[i] = 0;
			degen_flag = 1'b0;
			fail_count = 0;
			verdict_q.delete();
			pending_verdicts = 0;
		end else begin
			// results first: a word accepted in this cycle cannot finish here
			if (done) begin
				if (verdict_q.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("unexpected result inside=%0b degen=%0b", inside_res,
							degenerate_plane);
				end else begin
					want = verdict_q.pop_front();
					if (want.vis !== inside_res || want.degen !== degenerate_plane) begin
						fail_count++;
						if (fail_count <= 10)
							$display("mismatch: expected inside=%0b degen=%0b, got %0b %0b",
								want.vis, want.degen, inside_res, degenerate_plane);
					end
				end
			end
			if (start && !busy) begin
				if (func == FUNC_LOAD) begin
					mat[matrix_index] = matrix_value;
					if (last_element) extract_planes();
				end else begin
					lo = '{box_min_x, box_min_y, box_min_z};
					hi = '{box_max_x, box_max_y, box_max_z};
					want.vis = box_visible(lo, hi);
					want.degen = degen_flag;
					verdict_q.push_back(want);
				end
			end
			pending_verdicts = verdict_q.size();
		end
	end
endmodule

FILE: test/frustum_plane_extract_box_cull_unit_tb.sv
// Testbench top: drives load and box words into the cull unit and reports the verdict.
module frustum_plane_extract_box_cull_unit_tb import fpeb_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 4_000_000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               func = FUNC_LOAD;
	logic [3:0]         matrix_index = '0;
	logic signed [31:0] matrix_value = '0;
	logic               last_element = 1'b0;
	logic signed [31:0] box_min_x = '0, box_min_y = '0, box_min_z = '0;
	logic signed [31:0] box_max_x = '0, box_max_y = '0, box_max_z = '0;
	logic               done, inside_res, degenerate_plane;
	int                 fail_count, pending_verdicts;
	longint             cycle_count = 0;
	bit                 calm_stretch = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	frustum_plane_extract_box_cull_unit dut (.*);
	frustum_cull_checker chk (.*);

	// Hard stop for a hung block: extraction is long, so be generous.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// Pick a Q16.16 value: often small and well-scaled, sometimes an extreme.
	function automatic logic signed [31:0] pick_q();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2: return 32'($urandom());
			3: return 0;
			default: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
		endcase
	endfunction

	// Present one word, hold it until accepted, then sometimes drop start and idle.
	task automatic issue(input bit f, input logic [3:0] idx, input logic signed [31:0] val,
			input bit last, input logic signed [31:0] lx, ly, lz, hx, hy, hz);
		start <= 1'b1;
		func <= f;
		matrix_index <= idx;
		matrix_value <= val;
		last_element <= last;
		box_min_x <= lx; box_min_y <= ly; box_min_z <= lz;
		box_max_x <= hx; box_max_y <= hy; box_max_z <= hz;
		@(posedge clk);
		while (busy) @(posedge clk);
		// drop start only when an idle cycle follows
		if (!calm_stretch && $urandom_range(0, 99) < 17) begin
			start <= 1'b0;
			func <= ~func;
			matrix_value <= 32'($urandom());
			@(posedge clk);
			while ($urandom_range(0, 2) == 0) @(posedge clk);
		end
	endtask

	task automatic load_matrix(input int mode);
		logic signed [31:0] v;
		for (int i = 0; i < 16; i++) begin
			case (mode)
				0: v = 0;
				1: v = (i % 5 == 0) ? 32'sh0001_0000 : 0;
				default: v = pick_q();
			endcase
			issue(FUNC_LOAD, 4'(i), v, i == 15, pick_q(), pick_q(), pick_q(),
				pick_q(), pick_q(), pick_q());
		end
	endtask

	task automatic random_box();
		issue(FUNC_BOX, 4'($urandom()), 32'($urandom()), 1'($urandom()),
			pick_q(), pick_q(), pick_q(), pick_q(), pick_q(), pick_q());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// box before any extraction: zero planes, always inside
		issue(FUNC_BOX, 4'hF, 32'sh8000_0000, 1'b1, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
		// all-zero matrix: every normal degenerate
		load_matrix(0);
		issue(FUNC_BOX, 4'd0, 32'sd0, 1'b0, 32'sd1, 32'sd1, 32'sd1,
			-32'sd1, -32'sd1, -32'sd1);
		// identity: unit cube planes; inside, outside, and min above max
		load_matrix(1);
		issue(FUNC_BOX, 4'd0, 32'sd0, 1'b0, -32'sh8000, -32'sh8000, -32'sh8000,
			32'sh8000, 32'sh8000, 32'sh8000);
		issue(FUNC_BOX, 4'd0, 32'sd0, 1'b0, 32'sh0005_0000, 0, 0, 32'sh0006_0000, 0, 0);
		issue(FUNC_BOX, 4'd0, 32'sd0, 1'b0, 32'sh0001_0000, 0, 0, -32'sh0001_0000, 0, 0);
		// a load without the last marker, then a marked one; extreme values
		issue(FUNC_LOAD, 4'd3, 32'sh7FFF_FFFF, 1'b0, 0, 0, 0, 0, 0, 0);
		issue(FUNC_LOAD, 4'd7, 32'sh8000_0000, 1'b1, 0, 0, 0, 0, 0, 0);
		issue(FUNC_BOX, 4'd0, 32'sd0, 1'b0, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
			32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000);

		// random phase: a matrix then a burst of boxes, with odd loose loads
		for (int n = 0; n < 1900; ) begin
			calm_stretch = (n >= 800 && n < 1000);
			if ($urandom_range(0, 11) == 0) begin
				load_matrix(2);
				n += 16;
			end else if ($urandom_range(0, 9) == 0) begin
				issue(FUNC_LOAD, 4'($urandom()), pick_q(), 1'b0, 0, 0, 0, 0, 0, 0);
				n++;
			end else begin
				random_box();
				n++;
			end
		end
		start <= 1'b0;

		while (pending_verdicts != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (fail_count == 0) $display("DONE: 0 errors");
		else $display("DONE: errors detected");
		$finish;
	end
endmodule
